FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of i_clk, skip while reset is asserted.
`define SWSB_AST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check on every rising edge of i_clk, reset included.
`define SWSB_AST_NR(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: hdl/swsb_pkg.sv
// Types and constants of the sliding window send buffer.
package swsb_pkg;

    localparam int SEQ_W   = 32;
    localparam int WS_W    = 5;
    localparam int PDU_W   = 12;
    localparam int BIDX_W  = 11;
    localparam int BYTE_W  = 8;
    localparam logic [WS_W-1:0] WS_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_WRITE = 2'd1,
        OP_ACK   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [SEQ_W-1:0]   seq_num;
        logic [PDU_W-1:0]   pdu_size;
        logic [BIDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0]  data_byte;
    } t_item;

    typedef struct packed {
        logic               ok;
        logic               window_open;
        logic [SEQ_W-1:0]   current_count;
        logic [PDU_W-1:0]   size_out;
        logic [BYTE_W-1:0]  data_out;
    } t_result;

    typedef struct packed {
        logic               start;
        logic [SEQ_W-1:0]   dividend;
        logic [WS_W-1:0]    divisor;
    } t_mod_req;

    typedef struct packed {
        logic               done;
        logic [WS_W-1:0]    rem;
    } t_mod_rsp;

endpackage

FILE: hdl/sliding_window_send_buffer.sv
// Top level of the sliding window send buffer: sequencer, slot state and stores.
//
// Usage
//   Command channel: drive i_item and raise start; the word is taken at the
//   rising edge where start is high and busy is low. busy stays high while
//   the word is worked on. Exactly one result word per command appears on
//   o_result for a single cycle with o_done high; the receiver has no way to
//   hold it off and must take it then.
//   Flow: enqueue, payload write and read need the slot number, seq_num
//   (or the lower edge) modulo the window, from a shared bit-serial remainder
//   unit (S_MOD); enqueue and write then finish in S_EXEC, and a read also
//   passes S_READ for the registered store read. o_done rises as the block
//   returns to idle, so the next word can be taken while o_done is high. A
//   refused acknowledgement answers in the next cycle and leaves busy low; an
//   accepted one walks the outstanding slots one per cycle in S_ACK.
//   Configuration: i_cfg_we with i_cfg_wdata writes window_size; the user must
//   do so only while idle, as the block does not enforce it. The write drops
//   all valid bits and restarts counts and edges.
//   Reset (synchronous, i_rst_n low): window_size 16, no slot valid, counts
//   zero, window open, no result pending. Payload and size stores are not
//   cleared; only entries written since are meaningful.
module sliding_window_send_buffer #(
    parameter int WINDOW_MAX = 16,
    parameter int MAX_PDU    = 2048
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  swsb_pkg::t_item         i_item,
    output logic                    busy,
    input  logic                    i_cfg_we,
    input  logic [swsb_pkg::WS_W-1:0] i_cfg_wdata,
    output logic                    o_done,
    output swsb_pkg::t_result       o_result
);
    import swsb_pkg::*;

    localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int UW = $clog2(WINDOW_MAX + 1);
    localparam int PD = WINDOW_MAX * MAX_PDU;
    localparam int PW = (PD > 1) ? $clog2(PD) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_EXEC,
        S_READ,
        S_ACK
    } t_state;

    // state and registered outputs
    t_state                r_state,      n_state;
    t_item                 r_item,       n_item;
    logic [SW-1:0]         r_slot,       n_slot;
    logic [WINDOW_MAX-1:0] r_valid,      n_valid;
    logic [SEQ_W-1:0]      r_lower_edge, n_lower_edge;
    logic [SEQ_W-1:0]      r_next_count, n_next_count;
    logic [UW-1:0]         r_used,       n_used;
    logic                  r_open,       n_open;
    logic [SW-1:0]         r_next_slot,  n_next_slot;
    logic [SW-1:0]         r_low_slot,   n_low_slot;
    logic [SW-1:0]         r_walk_slot,  n_walk_slot;
    logic [SEQ_W-1:0]      r_walk_pos,   n_walk_pos;
    logic [UW-1:0]         r_walk_cnt,   n_walk_cnt;
    logic [WS_W-1:0]       r_wsize,      n_wsize;
    logic                  r_done,       n_done;
    t_result               r_result,     n_result;

    logic [WS_W-1:0]   w_eff;
    t_mod_req          mod_req;
    t_mod_rsp          mod_rsp;
    logic              bidx_ok;
    logic [PDU_W-1:0]  size_sat;
    logic [PW-1:0]     pl_addr;
    logic              sz_we, sz_re, pl_we, pl_re;
    logic [PDU_W-1:0]  sz_rdata;
    logic [BYTE_W-1:0] pl_rdata;
    logic              emit;
    logic              res_ok;
    logic [PDU_W-1:0]  res_size;
    logic [BYTE_W-1:0] res_data;

    // Saturate window_size to 1..WINDOW_MAX.
    always_comb begin
        if (r_wsize == '0) begin
            w_eff = WS_W'(1);
        end else if (32'(r_wsize) > 32'(WINDOW_MAX)) begin
            w_eff = WS_W'(WINDOW_MAX);
        end else begin
            w_eff = r_wsize;
        end
    end

    // Kick the remainder unit on accept for every op but acknowledgement.
    // A read looks at max(seq_num, lower_edge).
    assign mod_req.start    = (r_state == S_IDLE) && start && (i_item.op != OP_ACK);
    assign mod_req.dividend = ((i_item.op == OP_READ) && (i_item.seq_num < r_lower_edge))
                            ? r_lower_edge : i_item.seq_num;
    assign mod_req.divisor  = w_eff;

    swsb_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign bidx_ok  = 32'(r_item.byte_index) < 32'(MAX_PDU);
    assign size_sat = (32'(r_item.pdu_size) > 32'(MAX_PDU)) ? PDU_W'(MAX_PDU)
                                                            : r_item.pdu_size;
    // Each slot owns MAX_PDU consecutive payload bytes.
    assign pl_addr  = PW'(r_slot) * PW'(MAX_PDU) + PW'(r_item.byte_index);

    swsb_ram #(
        .WIDTH (PDU_W),
        .DEPTH (WINDOW_MAX)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (sz_we),
        .i_waddr (r_slot),
        .i_wdata (size_sat),
        .i_re    (sz_re),
        .i_raddr (r_slot),
        .o_rdata (sz_rdata)
    );

    swsb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PD)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_addr),
        .i_wdata (r_item.data_byte),
        .i_re    (pl_re),
        .i_raddr (pl_addr),
        .o_rdata (pl_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_slot       = r_slot;
        n_valid      = r_valid;
        n_lower_edge = r_lower_edge;
        n_next_count = r_next_count;
        n_used       = r_used;
        n_open       = r_open;
        n_next_slot  = r_next_slot;
        n_low_slot   = r_low_slot;
        n_walk_slot  = r_walk_slot;
        n_walk_pos   = r_walk_pos;
        n_walk_cnt   = r_walk_cnt;
        n_wsize      = r_wsize;
        n_done       = 1'b0;
        n_result     = r_result;
        sz_we        = 1'b0;
        sz_re        = 1'b0;
        pl_we        = 1'b0;
        pl_re        = 1'b0;
        emit         = 1'b0;
        res_ok       = 1'b0;
        res_size     = '0;
        res_data     = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    if (i_item.op == OP_ACK) begin
                        if (i_item.seq_num == r_next_count) begin
                            n_walk_slot = r_low_slot;
                            n_walk_pos  = r_lower_edge;
                            n_walk_cnt  = r_used;
                            n_state     = S_ACK;
                        end else begin
                            // refused: answer at once, no state change
                            emit = 1'b1;
                        end
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (mod_rsp.done) begin
                    n_slot  = SW'(mod_rsp.rem);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_item.op)
                    OP_ENQ: begin
                        if (32'(r_used) < 32'(w_eff)) begin
                            n_valid[r_slot] = 1'b1;
                            sz_we           = 1'b1;
                            n_used          = UW'(r_used + 1'b1);
                            n_next_count    = r_next_count + 1'b1;
                            // the count wrapping to zero lands on slot zero too
                            n_next_slot     = ((r_next_count == '1) ||
                                               (32'(r_next_slot) + 1 == 32'(w_eff)))
                                            ? '0 : SW'(r_next_slot + 1'b1);
                            if (32'(r_used) + 1 >= 32'(w_eff)) begin
                                n_open = 1'b0;
                            end
                            res_ok = 1'b1;
                        end
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_WRITE: begin
                        pl_we   = bidx_ok;
                        res_ok  = bidx_ok;
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_READ: begin
                        sz_re   = 1'b1;
                        pl_re   = 1'b1;
                        n_state = S_READ;
                    end
                    default: begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                res_ok   = r_valid[r_slot];
                res_size = sz_rdata;
                res_data = bidx_ok ? pl_rdata : '0;
                emit     = 1'b1;
                n_state  = S_IDLE;
            end
            S_ACK: begin
                if (r_walk_cnt == '0) begin
                    // slide the window up to the current count
                    n_lower_edge = r_next_count;
                    n_low_slot   = r_next_slot;
                    n_used       = '0;
                    n_open       = 1'b1;
                    res_ok       = 1'b1;
                    emit         = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    // drop one outstanding slot per cycle; a position wrapping
                    // to zero restarts at slot zero
                    n_valid[r_walk_slot] = 1'b0;
                    n_walk_slot = ((r_walk_pos == '1) ||
                                   (32'(r_walk_slot) + 1 == 32'(w_eff)))
                                ? '0 : SW'(r_walk_slot + 1'b1);
                    n_walk_pos  = r_walk_pos + 1'b1;
                    n_walk_cnt  = r_walk_cnt - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            n_done                 = 1'b1;
            n_result.ok            = res_ok;
            n_result.window_open   = n_open;
            n_result.current_count = n_next_count;
            n_result.size_out      = res_size;
            n_result.data_out      = res_data;
        end

        // window_size write restarts the window
        if (i_cfg_we) begin
            n_wsize      = i_cfg_wdata;
            n_valid      = '0;
            n_lower_edge = '0;
            n_next_count = '0;
            n_used       = '0;
            n_open       = 1'b1;
            n_next_slot  = '0;
            n_low_slot   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_lower_edge <= '0;
            r_next_count <= '0;
            r_used       <= '0;
            r_open       <= 1'b1;
            r_next_slot  <= '0;
            r_low_slot   <= '0;
            r_walk_slot  <= '0;
            r_walk_pos   <= '0;
            r_walk_cnt   <= '0;
            r_wsize      <= WS_RESET;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_lower_edge <= n_lower_edge;
            r_next_count <= n_next_count;
            r_used       <= n_used;
            r_open       <= n_open;
            r_next_slot  <= n_next_slot;
            r_low_slot   <= n_low_slot;
            r_walk_slot  <= n_walk_slot;
            r_walk_pos   <= n_walk_pos;
            r_walk_cnt   <= n_walk_cnt;
            r_wsize      <= n_wsize;
            r_done       <= n_done;
        end
        r_item   <= n_item;
        r_slot   <= n_slot;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: hdl/swsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/swsb_mod.sv
// Bit-serial remainder unit: dividend modulo a small divisor, one bit a cycle.
module swsb_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swsb_pkg::t_mod_req i_req,
    output swsb_pkg::t_mod_rsp o_rsp
);
    import swsb_pkg::*;

    localparam int CNT_W = $clog2(SEQ_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SEQ_W-1:0] r_dvd;
    logic [WS_W-1:0]  r_div;
    logic [WS_W-1:0]  r_rem;

    logic [WS_W:0]    trial;
    logic             fits;
    logic [WS_W-1:0]  rem_step;

    // shift in the next dividend bit, subtract when the divisor fits
    assign trial    = {r_rem, r_dvd[SEQ_W-1]};
    assign fits     = trial >= {1'b0, r_div};
    assign rem_step = fits ? WS_W'(trial - {1'b0, r_div}) : WS_W'(trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem <= rem_step;
                r_dvd <= {r_dvd[SEQ_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_dvd  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(SEQ_W);
                r_busy <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

FILE: hdl/swsb_checker.sv
// Port-level checker for the sliding window send buffer, with its bind.
`include "assert_macros.svh"

module swsb_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input swsb_pkg::t_item i_item,
    input logic            busy,
    input logic            o_done
);
    import swsb_pkg::*;

    // reset leaves nothing pending
    `SWSB_AST_NR(a_reset_quiet, !i_rst_n |=> (!o_done && !busy), "result or busy after reset")

    // every result closes its command, so the block is idle with it
    `SWSB_AST(a_done_idle, o_done |-> !busy, "result strobe while busy")

    // leaving busy always delivers a result
    `SWSB_AST(a_busy_ends_done, ($past(i_rst_n) && $fell(busy)) |-> o_done, "busy dropped without a result")

    // commands needing a slot number go busy right after acceptance
    `SWSB_AST(a_slot_op_busy, (start && !busy && (i_item.op != OP_ACK)) |=> busy, "slot command not started")

endmodule

bind sliding_window_send_buffer swsb_checker u_swsb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_item  (i_item),
    .busy    (busy),
    .o_done  (o_done)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the sliding window send buffer.
module tb_top;

    import swsb_pkg::*;

    localparam int unsigned SLOTS      = 16;
    localparam int unsigned PDU_MAX    = 2048;
    localparam int unsigned CYCLE_CAP  = 600000;
    localparam int unsigned PRINT_CAP  = 40;

    // Clock, reset and DUT ports; every input starts at a known value.
    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     start     = 1'b0;
    t_item    item_bus  = '0;
    logic     busy;
    logic     cfg_we    = 1'b0;
    logic [WS_W-1:0] cfg_wdata = '0;
    logic     done;
    t_result  result_bus;

    // Mirror of the buffer: window register, slot state, stores and counts.
    logic [WS_W-1:0]  win_reg;
    bit               frame_valid [SLOTS];
    logic [PDU_W-1:0] frame_len [SLOTS];
    logic [BYTE_W-1:0] pdu_mem [SLOTS*PDU_MAX];
    logic [SEQ_W-1:0] lower_seq;
    logic [SEQ_W-1:0] sent_count;
    int unsigned      in_flight;
    bit               win_open;

    // Which store entries hold written data; stores survive reset and config.
    bit               len_known [SLOTS];
    bit               byte_known [SLOTS*PDU_MAX];
    int               last_idx [SLOTS];

    t_result          awaited_results [$];
    bit               gaps_on = 1'b1;
    int unsigned      cycle_count = 0;
    int unsigned      mismatches = 0;
    int unsigned      words_sent = 0;
    int unsigned      windows_tried = 0;
    int unsigned      acks_taken = 0;
    int unsigned      full_refusals = 0;
    int unsigned      valid_reads = 0;

    sliding_window_send_buffer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .i_item      (item_bus),
        .busy        (busy),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_done      (done),
        .o_result    (result_bus)
    );

    always #5 clk = ~clk;

    // Abort on a hung run; the cap is several times the slowest legal run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h",
                     cycle_count, what, got, want);
    endtask

    // Window size saturated to 1..16, as the buffer uses it.
    function automatic int unsigned slots_in_use();
        if (win_reg == 0) return 1;
        if (win_reg > SLOTS) return SLOTS;
        return win_reg;
    endfunction

    // Reload the window register: drop all frames and restart counts.
    function automatic void load_window(input logic [WS_W-1:0] ws);
        win_reg = ws;
        foreach (frame_valid[i]) frame_valid[i] = 1'b0;
        lower_seq  = '0;
        sent_count = '0;
        in_flight  = 0;
        win_open   = 1'b1;
    endfunction

    // Advance the mirror by one accepted word and return the word it answers.
    function automatic t_result buffer_response(input t_item w);
        int unsigned win;
        int unsigned s;
        int unsigned i;
        logic [SEQ_W-1:0] pos;
        t_result r;
        win = slots_in_use();
        r = '0;
        case (w.op)
            OP_ENQ: begin
                if (in_flight < win) begin
                    s = w.seq_num % win;
                    frame_valid[s] = 1'b1;
                    frame_len[s] = (w.pdu_size > PDU_MAX) ? PDU_W'(PDU_MAX) : w.pdu_size;
                    len_known[s] = 1'b1;
                    in_flight++;
                    sent_count++;
                    if (in_flight >= win) win_open = 1'b0;
                    r.ok = 1'b1;
                end else begin
                    full_refusals++;
                end
            end
            OP_WRITE: begin
                if (w.byte_index < PDU_MAX) begin
                    s = w.seq_num % win;
                    pdu_mem[s*PDU_MAX + w.byte_index] = w.data_byte;
                    byte_known[s*PDU_MAX + w.byte_index] = 1'b1;
                    last_idx[s] = w.byte_index;
                    r.ok = 1'b1;
                end
            end
            OP_ACK: begin
                if (w.seq_num == sent_count) begin
                    // Free the outstanding slots walking up from the lower edge.
                    for (i = 0; i < in_flight && i < SLOTS; i++) begin
                        pos = lower_seq + i;
                        frame_valid[pos % win] = 1'b0;
                    end
                    lower_seq = sent_count;
                    in_flight = 0;
                    win_open  = 1'b1;
                    r.ok = 1'b1;
                    acks_taken++;
                end
            end
            default: begin
                // Reads below the lower edge land on the lower edge slot.
                pos = (w.seq_num < lower_seq) ? lower_seq : w.seq_num;
                s = pos % win;
                r.ok = frame_valid[s];
                r.size_out = frame_len[s];
                if (w.byte_index < PDU_MAX)
                    r.data_out = pdu_mem[s*PDU_MAX + w.byte_index];
                if (frame_valid[s]) valid_reads++;
            end
        endcase
        r.window_open = win_open;
        r.current_count = sent_count;
        return r;
    endfunction

    function automatic t_item make_word(input t_op op, input logic [SEQ_W-1:0] seq,
                                        input logic [PDU_W-1:0] len,
                                        input logic [BIDX_W-1:0] idx,
                                        input logic [BYTE_W-1:0] val);
        t_item w;
        w.op = op;
        w.seq_num = seq;
        w.pdu_size = len;
        w.byte_index = idx;
        w.data_byte = val;
        return w;
    endfunction

    // Build a read that only touches stored entries; return 0 if none exist yet.
    function automatic bit pick_read(inout t_item w);
        int unsigned win;
        int unsigned s;
        int unsigned k;
        int unsigned mode;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] pos;
        bit found;
        win = slots_in_use();
        mode = $urandom_range(99);
        if (mode < 60) seq = lower_seq + $urandom_range(0, 2*win);
        else if (mode < 80 || lower_seq == 0) seq = $urandom;
        else seq = $urandom_range(0, lower_seq - 1);
        pos = (seq < lower_seq) ? lower_seq : seq;
        s = pos % win;
        if (!(len_known[s] && last_idx[s] >= 0)) begin
            found = 1'b0;
            for (k = 0; k < win && !found; k++) begin
                if (len_known[(lower_seq + k) % win] && last_idx[(lower_seq + k) % win] >= 0)
                begin
                    found = 1'b1;
                    s = (lower_seq + k) % win;
                    seq = lower_seq + k;
                end
            end
            if (!found) return 1'b0;
        end
        w.op = OP_READ;
        w.seq_num = seq;
        w.byte_index = BIDX_W'(last_idx[s]);
        k = $urandom_range(0, 15);
        if ($urandom_range(1) == 1 && byte_known[s*PDU_MAX + k]) w.byte_index = BIDX_W'(k);
        if ($urandom_range(9) == 0 && byte_known[s*PDU_MAX + PDU_MAX - 1])
            w.byte_index = BIDX_W'(PDU_MAX - 1);
        return 1'b1;
    endfunction

    // Mostly well-formed frame traffic: enqueue at the count, fill, read, ack.
    function automatic t_item random_word();
        t_item w;
        int unsigned win;
        int unsigned roll;
        win = slots_in_use();
        w.seq_num = $urandom;
        w.pdu_size = PDU_W'($urandom);
        w.byte_index = BIDX_W'($urandom);
        w.data_byte = BYTE_W'($urandom);
        roll = $urandom_range(99);
        if (!win_open && $urandom_range(99) < 55) roll = 70;
        if (roll < 30) begin
            w.op = OP_ENQ;
            if ($urandom_range(99) < 75) w.seq_num = sent_count;
            case ($urandom_range(9))
                0:       w.pdu_size = '0;
                1:       w.pdu_size = PDU_W'(PDU_MAX);
                2:       w.pdu_size = PDU_W'($urandom_range(PDU_MAX + 1, 4095));
                default: w.pdu_size = PDU_W'($urandom_range(0, PDU_MAX));
            endcase
        end else if (roll < 65) begin
            w.op = OP_WRITE;
            if ($urandom_range(99) < 60) w.seq_num = lower_seq + $urandom_range(0, in_flight);
            case ($urandom_range(9))
                0, 1:    ;
                2:       w.byte_index = BIDX_W'(PDU_MAX - 1);
                default: w.byte_index = BIDX_W'($urandom_range(0, 15));
            endcase
        end else if (roll < 77) begin
            w.op = OP_ACK;
            case ($urandom_range(19))
                0, 1:    w.seq_num = sent_count + 1;
                2:       w.seq_num = sent_count - 1;
                3, 4:    ;
                default: w.seq_num = sent_count;
            endcase
        end else begin
            // Fall back to a payload write until some stored slot can be read.
            if (!pick_read(w)) begin
                w.op = OP_WRITE;
                w.byte_index = BIDX_W'($urandom_range(0, 15));
            end
        end
        return w;
    endfunction

    // Offer one word and hold it until the DUT takes it, then predict its result.
    // The caller either sends again or lowers start in the same time step.
    task automatic send_word(input t_item w);
        if (gaps_on && $urandom_range(99) < 33) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge clk);
        end
        start <= 1'b1;
        item_bus <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        awaited_results.push_back(buffer_response(w));
        words_sent++;
    endtask

    // Drop start and hold until every awaited result is in and the DUT is idle.
    task automatic wait_drained();
        start <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic set_window(input logic [WS_W-1:0] ws);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= ws;
        @(posedge clk);
        cfg_we <= 1'b0;
        load_window(ws);
        windows_tried++;
    endtask

    // Check each result word against the oldest prediction.
    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && done) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result word with nothing awaited", result_bus[31:0], '0);
            end else begin
                want = awaited_results.pop_front();
                if (result_bus.ok !== want.ok)
                    report_mismatch("ok", result_bus.ok, want.ok);
                if (result_bus.window_open !== want.window_open)
                    report_mismatch("window_open", result_bus.window_open, want.window_open);
                if (result_bus.current_count !== want.current_count)
                    report_mismatch("current_count", result_bus.current_count,
                                    want.current_count);
                if (result_bus.size_out !== want.size_out)
                    report_mismatch("size_out", result_bus.size_out, want.size_out);
                if (result_bus.data_out !== want.data_out)
                    report_mismatch("data_out", result_bus.data_out, want.data_out);
            end
        end
    end

    // Default window: empty ack, oversized length, index extremes, all-ones
    // sequence number, wrong ack, good ack, read below the lower edge.
    task automatic test_after_reset();
        send_word(make_word(OP_ACK,   32'd0,          12'd0,    11'd0,    8'h00));
        send_word(make_word(OP_ENQ,   32'd0,          12'd4095, 11'd0,    8'h00));
        send_word(make_word(OP_WRITE, 32'd0,          12'd0,    11'd0,    8'hFF));
        send_word(make_word(OP_WRITE, 32'd16,         12'd0,    11'd2047, 8'h00));
        send_word(make_word(OP_READ,  32'd0,          12'd0,    11'd0,    8'h00));
        send_word(make_word(OP_READ,  32'd0,          12'd0,    11'd2047, 8'h00));
        send_word(make_word(OP_ENQ,   32'hFFFF_FFFF,  12'd0,    11'd0,    8'h00));
        send_word(make_word(OP_WRITE, 32'hFFFF_FFFF,  12'd0,    11'd1024, 8'hA5));
        send_word(make_word(OP_READ,  32'hFFFF_FFFF,  12'd0,    11'd1024, 8'h00));
        send_word(make_word(OP_ACK,   32'd5,          12'd0,    11'd0,    8'h00));
        send_word(make_word(OP_ACK,   32'd2,          12'd0,    11'd0,    8'h00));
        send_word(make_word(OP_ENQ,   32'd2,          12'd2048, 11'd0,    8'h00));
        send_word(make_word(OP_WRITE, 32'd2,          12'd0,    11'd3,    8'h5A));
        send_word(make_word(OP_READ,  32'd0,          12'd0,    11'd3,    8'h00));
        wait_drained();
    endtask

    // Window size zero acts as one slot: fill it, get refused, read, release.
    task automatic test_tiny_window();
        set_window(5'd0);
        send_word(make_word(OP_ENQ,   32'd7, 12'd2049, 11'd0, 8'h00));
        send_word(make_word(OP_ENQ,   32'd8, 12'd1,    11'd0, 8'h00));
        send_word(make_word(OP_WRITE, 32'd9, 12'd0,    11'd0, 8'h3C));
        send_word(make_word(OP_READ,  32'd0, 12'd0,    11'd0, 8'h00));
        send_word(make_word(OP_ACK,   32'd1, 12'd0,    11'd0, 8'h00));
        send_word(make_word(OP_READ,  32'd5, 12'd0,    11'd0, 8'h00));
        wait_drained();
    endtask

    // Window size above the slot count saturates to sixteen.
    task automatic test_oversized_window_cfg();
        set_window(5'd31);
        send_word(make_word(OP_ENQ,   32'd17, 12'd100, 11'd0,    8'h00));
        send_word(make_word(OP_WRITE, 32'd17, 12'd0,   11'd2047, 8'hC3));
        send_word(make_word(OP_READ,  32'd17, 12'd0,   11'd2047, 8'h00));
        send_word(make_word(OP_ACK,   32'd0,  12'd0,   11'd0,    8'h00));
        wait_drained();
    endtask

    task automatic test_random_traffic(input logic [WS_W-1:0] ws, input int count,
                                       input bit gaps);
        set_window(ws);
        gaps_on = gaps;
        repeat (count) begin
            send_word(random_word());
            // Now and then hold off until the buffer has answered everything.
            if ($urandom_range(99) < 2) wait_drained();
        end
        wait_drained();
        gaps_on = 1'b1;
    endtask

    initial begin
        win_reg = WS_RESET;
        load_window(WS_RESET);
        foreach (last_idx[i]) last_idx[i] = -1;

        // Hold reset, then release it for good.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_tiny_window();
        test_oversized_window_cfg();
        test_random_traffic(5'd1,  120, 1'b1);
        test_random_traffic(5'd16, 150, 1'b1);
        test_random_traffic(5'd5,  120, 1'b1);
        test_random_traffic(5'd16, 200, 1'b0);
        test_random_traffic(5'd3,  110, 1'b1);
        test_random_traffic(5'd31, 130, 1'b1);
        test_random_traffic(5'd8,  130, 1'b1);
        test_random_traffic(5'd0,  100, 1'b1);
        test_random_traffic(5'd2,  110, 1'b1);
        test_random_traffic(5'd13, 130, 1'b1);
        test_random_traffic(5'd16, 200, 1'b1);

        // Let any stray result word show up before closing.
        wait_drained();
        repeat (40) @(posedge clk);
        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", awaited_results.size(), 0);

        $display("covered %0d words over %0d window settings in %0d cycles",
                 words_sent, windows_tried, cycle_count);
        $display("  %0d acks taken, %0d full-window refusals, %0d reads of live frames",
                 acks_taken, full_refusals, valid_reads);
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
